>>> src/image_resample_forward_macros.svh
// ----------------------------------------------------------------------------
// Image resampler assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in rst.
// ----------------------------------------------------------------------------
`ifndef IMAGE_RESAMPLE_FORWARD_MACROS_SVH
`define IMAGE_RESAMPLE_FORWARD_MACROS_SVH

// same-cycle implication
`define IRF_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define IRF_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> src/irf_pkg.sv
// ----------------------------------------------------------------------------
// Image resampler package
// Constants, register codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
package irf_pkg;

  localparam int IN_DIM  = 64;
  localparam int OUT_DIM = 256;
  localparam int ONE_W   = 16384;

  localparam logic [1:0] MODE_NEAREST  = 2'd0;
  localparam logic [1:0] MODE_BILINEAR = 2'd1;
  localparam logic [1:0] MODE_CUBIC50  = 2'd2;
  localparam logic [1:0] MODE_CUBIC75  = 2'd3;

  localparam logic [2:0] REG_MODE    = 3'd0;
  localparam logic [2:0] REG_ALIGNED = 3'd1;
  localparam logic [2:0] REG_IN_H    = 3'd2;
  localparam logic [2:0] REG_IN_W    = 3'd3;
  localparam logic [2:0] REG_OUT_H   = 3'd4;
  localparam logic [2:0] REG_OUT_W   = 3'd5;

  typedef struct packed {
    logic [1:0] mode;
    logic       aligned;
    logic [6:0] in_h;
    logic [6:0] in_w;
    logic [8:0] out_h;
    logic [8:0] out_w;
  } cfg_t;

  typedef struct packed {
    logic accept_req;
    logic store_wr;
    logic set_oob;
    logic div_load;
    logic div_step;
    logic div_save;
    logic setup;
    logic w_sq;
    logic w_cube;
    logic w_fin;
    logic t_mul;
    logic t_acc;
    logic r_mul;
    logic r_acc;
    logic fin;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic in_range;
    logic div_last;
    logic axis;
    logic cubic;
    logic w_last;
    logic k_last;
    logic j_last;
  } sts_t;

endpackage

>>> src/image_resample_forward.sv
// ----------------------------------------------------------------------------
// Image resampler, forward pass
// Nearest, bilinear and bicubic resampling of one stored image plane.
// ----------------------------------------------------------------------------
// Input stream s_*: tuser is kind (0 load, 1 request). A load transfer writes
// its sample into the 64x64 frame store if row and col are below 64, and the
// block stays idle. A request names an output pixel and yields one result
// transfer on m_*. Two 31-step serial divisions for the coordinates, kernel
// weight evaluation (bicubic only), then the frame-store taps and tap rows on
// the multiply-accumulate datapath make up the work of a request. One request
// is in work at a time; s_tready is high only while the block is idle. A
// request outside the output size returns status 1 and pixel 0.
// The result sits in an output register; a stalled receiver holds it while
// the block returns to idle and accepts the next transfer.
// Reset clears control state and restores the register defaults; the frame
// store is not cleared and holds no meaning until written.
// Configuration writes are taken in any cycle on cfg_*; write only when idle.
// ----------------------------------------------------------------------------
module image_resample_forward import irf_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // row[7:0], col[15:8], sample[31:16]
  input  logic        s_tuser,   // kind[0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // pixel[15:0], out_row[23:16], out_col[31:24]
  output logic        m_tuser,   // status[0]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [8:0]  cfg_data
);

  cfg_t cfg;
  cmd_t cmd;
  sts_t sts;

  irf_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  irf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .kind     (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  irf_dp u_dp (
    .clk     (clk),
    .cfg     (cfg),
    .cmd     (cmd),
    .s_tdata (s_tdata),
    .sts     (sts),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser)
  );

endmodule

>>> src/irf_cfg.sv
// ----------------------------------------------------------------------------
// Image resampler configuration registers
// Write-only register file on the configuration channel.
// ----------------------------------------------------------------------------
module irf_cfg import irf_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [2:0] cfg_index,
  input  logic [8:0] cfg_data,
  output cfg_t       cfg
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mode    <= MODE_BILINEAR;
      cfg.aligned <= 1'b0;
      cfg.in_h    <= 7'd64;
      cfg.in_w    <= 7'd64;
      cfg.out_h   <= 9'd64;
      cfg.out_w   <= 9'd64;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_MODE:    cfg.mode    <= cfg_data[1:0];
        REG_ALIGNED: cfg.aligned <= cfg_data[0];
        REG_IN_H:    cfg.in_h    <= cfg_data[6:0];
        REG_IN_W:    cfg.in_w    <= cfg_data[6:0];
        REG_OUT_H:   cfg.out_h   <= cfg_data;
        REG_OUT_W:   cfg.out_w   <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

>>> src/irf_dp.sv
// ----------------------------------------------------------------------------
// Image resampler datapath
// Frame store, serial coordinate divider, kernel weight unit, shared MAC.
// ----------------------------------------------------------------------------
module irf_dp import irf_pkg::*; (
  input  logic        clk,
  input  cfg_t        cfg,
  input  cmd_t        cmd,
  input  logic [31:0] s_tdata,
  output sts_t        sts,
  output logic [31:0] m_tdata,
  output logic        m_tuser
);

  function automatic logic [6:0] fit_in(input logic [6:0] v);
    logic [6:0] r;
    if (v == 7'd0) r = 7'd1;
    else if (v > 7'(IN_DIM)) r = 7'(IN_DIM);
    else r = v;
    return r;
  endfunction

  function automatic logic [8:0] fit_out(input logic [8:0] v);
    logic [8:0] r;
    if (v == 9'd0) r = 9'd1;
    else if (v > 9'(OUT_DIM)) r = 9'(OUT_DIM);
    else r = v;
    return r;
  endfunction

  function automatic logic [8:0] tap_base(input logic [1:0] mode, input logic [7:0] ip,
                                          input logic [15:0] frac, input logic exact);
    logic up;
    logic [8:0] b;
    up = (frac > 16'h8000) || (frac == 16'h8000 && (!exact || ip[0]));
    case (mode)
      MODE_NEAREST:  b = {ip[7], ip} + {8'd0, up};
      MODE_BILINEAR: b = {ip[7], ip};
      default:       b = {ip[7], ip} - 9'd1;
    endcase
    return b;
  endfunction

  function automatic logic [14:0] quant_w(input logic [15:0] frac);
    logic [16:0] s;
    s = {1'b0, frac} + 17'd2;
    return s[16:2];
  endfunction

  function automatic logic [5:0] clamp_idx(input logic signed [9:0] v, input logic [6:0] dim);
    logic [5:0] r;
    logic [6:0] dm1;
    dm1 = dim - 7'd1;
    if (v < 10'sd0) r = 6'd0;
    else if (v > $signed({3'b0, dm1})) r = dm1[5:0];
    else r = v[5:0];
    return r;
  endfunction

  logic [7:0]  in_row, in_col;
  logic signed [15:0] in_sample;
  logic [6:0]  in_h, in_w;
  logic [8:0]  out_h, out_w;

  logic [7:0]  req_row, req_col;
  logic        axis;

  logic [7:0]  o_sel;
  logic [6:0]  i_sel;
  logic [8:0]  d_sel;
  logic [15:0] odd_prod;
  logic [14:0] al_prod;
  logic signed [17:0] num_s;
  logic [17:0] mag;
  logic [9:0]  den;
  logic [30:0] dvd, quo;
  logic [9:0]  rem, den_r;
  logic        neg;
  logic [4:0]  cnt;
  logic [10:0] trial, diff;
  logic        ge;
  logic [31:0] qmag, qs;
  logic        rnz;

  logic [7:0]  y_ip, x_ip;
  logic [15:0] y_frac, x_frac;
  logic        y_exact, x_exact;
  logic [8:0]  base_y, base_x;
  logic [14:0] qw_y, qw_x;

  logic signed [15:0] wy [4];
  logic signed [15:0] wx [4];
  logic [2:0]  widx;
  logic [14:0] q_sel;
  logic [15:0] t;
  logic [31:0] t2;
  logic [47:0] t3;
  logic        a75;
  logic signed [51:0] s1, s2, s3, pa, pb, inner, num, wsum;
  logic signed [15:0] w_new;

  logic [1:0]  k, j, nlast;
  logic [5:0]  ry, rx;
  logic signed [15:0] store [IN_DIM * IN_DIM];
  logic signed [15:0] rdata;
  logic signed [31:0] prod;
  logic signed [33:0] rowsum;
  logic signed [49:0] rprod;
  logic signed [51:0] acc, rnd;
  logic signed [23:0] v;
  logic signed [15:0] sat;
  logic signed [15:0] res_pixel;
  logic        res_status;

  assign in_row    = s_tdata[7:0];
  assign in_col    = s_tdata[15:8];
  assign in_sample = s_tdata[31:16];
  assign in_h  = fit_in(cfg.in_h);
  assign in_w  = fit_in(cfg.in_w);
  assign out_h = fit_out(cfg.out_h);
  assign out_w = fit_out(cfg.out_w);

  // coordinate numerator and denominator for the current axis, divider step and signed quotient
  always_comb begin
    o_sel    = axis ? req_col : req_row;
    i_sel    = axis ? in_w : in_h;
    d_sel    = axis ? out_w : out_h;
    odd_prod = 16'({o_sel, 1'b1}) * 16'(i_sel);
    al_prod  = 15'(o_sel) * 15'(i_sel - 7'd1);
    if (cfg.aligned) begin
      if (d_sel == 9'd1) begin
        num_s = 18'sd0;
        den   = 10'd1;
      end else begin
        num_s = $signed({3'b0, al_prod});
        den   = {1'b0, d_sel - 9'd1};
      end
    end else begin
      num_s = $signed({2'b0, odd_prod}) - $signed({9'b0, d_sel});
      den   = {d_sel, 1'b0};
    end
    mag   = num_s[17] ? 18'(-num_s) : num_s;
    trial = {rem, dvd[30]};
    ge    = trial >= {1'b0, den_r};
    diff  = trial - {1'b0, den_r};
    rnz   = rem != 10'd0;
    qmag  = {1'b0, quo};
    qs    = neg ? (32'd0 - qmag - {31'd0, rnz}) : qmag;
  end

  // Keys kernel at t, Q14 in and out
  always_comb begin
    q_sel = widx[2] ? qw_x : qw_y;
    case (widx[1:0])
      2'd0:    t = 16'(ONE_W) + {1'b0, q_sel};
      2'd1:    t = {1'b0, q_sel};
      2'd2:    t = 16'(ONE_W) - {1'b0, q_sel};
      default: t = 16'(2 * ONE_W) - {1'b0, q_sel};
    endcase
    a75   = cfg.mode == MODE_CUBIC75;
    s1    = $signed({36'd0, t});
    s2    = $signed({20'd0, t2});
    s3    = $signed({4'd0, t3});
    pa    = (a75 ? (s3 <<< 2) + s3 : (s3 <<< 2) + (s3 <<< 1))
          - (a75 ? (s2 <<< 17) + (s2 <<< 14) : (s2 <<< 17) + (s2 <<< 15))
          + (52'sd1 <<< 44);
    inner = s3 - ((s2 <<< 16) + (s2 <<< 14)) + (s1 <<< 31) - (52'sd1 <<< 44);
    pb    = a75 ? -((inner <<< 1) + inner) : -(inner <<< 1);
    if (t < 16'(ONE_W)) num = pa;
    else if (t < 16'(2 * ONE_W)) num = pb;
    else num = 52'sd0;
    wsum  = num + (52'sd1 <<< 29);
    w_new = wsum[45:30];
  end

  always_comb begin
    case (cfg.mode)
      MODE_NEAREST:  nlast = 2'd0;
      MODE_BILINEAR: nlast = 2'd1;
      default:       nlast = 2'd3;
    endcase
    ry  = clamp_idx($signed({base_y[8], base_y}) + $signed({8'd0, j}), in_h);
    rx  = clamp_idx($signed({base_x[8], base_x}) + $signed({8'd0, k}), in_w);
    rnd = acc + (52'sd1 <<< 27);
    v   = rnd[51:28];
    if (v > 24'sd32767) sat = 16'sh7FFF;
    else if (v < -24'sd32768) sat = -16'sh8000;
    else sat = v[15:0];
  end

  always_ff @(posedge clk) begin
    if (cmd.store_wr && in_row[7:6] == 2'd0 && in_col[7:6] == 2'd0) begin
      store[{in_row[5:0], in_col[5:0]}] <= in_sample;
    end
    rdata <= store[{ry, rx}];
  end

  always_ff @(posedge clk) begin
    if (cmd.accept_req) begin
      req_row <= in_row;
      req_col <= in_col;
      axis    <= 1'b0;
    end
    if (cmd.div_load) begin
      dvd   <= {mag[14:0], 16'd0};
      quo   <= '0;
      rem   <= '0;
      cnt   <= '0;
      den_r <= den;
      neg   <= num_s[17];
    end
    if (cmd.div_step) begin
      rem <= ge ? diff[9:0] : trial[9:0];
      dvd <= {dvd[29:0], 1'b0};
      quo <= {quo[29:0], ge};
      cnt <= cnt + 5'd1;
    end
    if (cmd.div_save) begin
      if (axis) begin
        x_ip    <= qs[23:16];
        x_frac  <= qs[15:0];
        x_exact <= !rnz;
      end else begin
        y_ip    <= qs[23:16];
        y_frac  <= qs[15:0];
        y_exact <= !rnz;
      end
      axis <= !axis;
    end
    if (cmd.setup) begin
      base_y <= tap_base(cfg.mode, y_ip, y_frac, y_exact);
      base_x <= tap_base(cfg.mode, x_ip, x_frac, x_exact);
      qw_y   <= quant_w(y_frac);
      qw_x   <= quant_w(x_frac);
      widx   <= '0;
      k      <= '0;
      j      <= '0;
      if (cfg.mode == MODE_BILINEAR) begin
        wy[0] <= 16'(ONE_W) - {1'b0, quant_w(y_frac)};
        wy[1] <= {1'b0, quant_w(y_frac)};
        wx[0] <= 16'(ONE_W) - {1'b0, quant_w(x_frac)};
        wx[1] <= {1'b0, quant_w(x_frac)};
      end else begin
        wy[0] <= 16'(ONE_W);
        wy[1] <= '0;
        wx[0] <= 16'(ONE_W);
        wx[1] <= '0;
      end
      wy[2] <= '0;
      wy[3] <= '0;
      wx[2] <= '0;
      wx[3] <= '0;
    end
    if (cmd.w_sq) t2 <= 32'(t) * 32'(t);
    if (cmd.w_cube) t3 <= t2 * t;
    if (cmd.w_fin) begin
      if (widx[2]) wx[widx[1:0]] <= w_new;
      else wy[widx[1:0]] <= w_new;
      widx <= widx + 3'd1;
    end
    if (cmd.t_mul) prod <= wx[k] * rdata;
    if (cmd.t_acc) begin
      rowsum <= (k == 2'd0) ? 34'(prod) : rowsum + 34'(prod);
      k      <= (k == nlast) ? 2'd0 : k + 2'd1;
    end
    if (cmd.r_mul) rprod <= wy[j] * rowsum;
    if (cmd.r_acc) begin
      acc <= (j == 2'd0) ? 52'(rprod) : acc + 52'(rprod);
      j   <= j + 2'd1;
    end
    if (cmd.set_oob) begin
      res_pixel  <= '0;
      res_status <= 1'b1;
    end
    if (cmd.fin) begin
      res_pixel  <= sat;
      res_status <= 1'b0;
    end
    if (cmd.out_load) begin
      m_tdata <= {req_col, req_row, res_pixel};
      m_tuser <= res_status;
    end
  end

  assign sts.in_range = ({1'b0, req_row} < out_h) && ({1'b0, req_col} < out_w);
  assign sts.div_last = cnt == 5'd30;
  assign sts.axis     = axis;
  assign sts.cubic    = cfg.mode[1];
  assign sts.w_last   = widx == 3'd7;
  assign sts.k_last   = k == nlast;
  assign sts.j_last   = j == nlast;

endmodule

>>> src/irf_ctrl.sv
// ----------------------------------------------------------------------------
// Image resampler controller
// Sequences loads, coordinate division, weights, taps and result transfer.
// ----------------------------------------------------------------------------
`include "image_resample_forward_macros.svh"

module irf_ctrl import irf_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  input  logic kind,
  output logic m_tvalid,
  input  logic m_tready,
  input  sts_t sts,
  output cmd_t cmd
);

  typedef enum logic [15:0] {
    S_IDLE    = 16'h0001,
    S_CHECK   = 16'h0002,
    S_DIVLOAD = 16'h0004,
    S_DIV     = 16'h0008,
    S_DIVSAVE = 16'h0010,
    S_SETUP   = 16'h0020,
    S_WSQ     = 16'h0040,
    S_WCUBE   = 16'h0080,
    S_WFIN    = 16'h0100,
    S_TRD     = 16'h0200,
    S_TMUL    = 16'h0400,
    S_TACC    = 16'h0800,
    S_RMUL    = 16'h1000,
    S_RACC    = 16'h2000,
    S_FIN     = 16'h4000,
    S_DONE    = 16'h8000
  } state_t;

  state_t state, state_next;

  assign s_tready = state == S_IDLE;

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          if (kind) begin
            cmd.accept_req = 1'b1;
            state_next     = S_CHECK;
          end else begin
            cmd.store_wr = 1'b1;
          end
        end
      end
      S_CHECK: begin
        if (sts.in_range) begin
          state_next = S_DIVLOAD;
        end else begin
          cmd.set_oob = 1'b1;
          state_next  = S_DONE;
        end
      end
      S_DIVLOAD: begin
        cmd.div_load = 1'b1;
        state_next   = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) state_next = S_DIVSAVE;
      end
      S_DIVSAVE: begin
        cmd.div_save = 1'b1;
        state_next   = sts.axis ? S_SETUP : S_DIVLOAD;
      end
      S_SETUP: begin
        cmd.setup  = 1'b1;
        state_next = sts.cubic ? S_WSQ : S_TRD;
      end
      S_WSQ: begin
        cmd.w_sq   = 1'b1;
        state_next = S_WCUBE;
      end
      S_WCUBE: begin
        cmd.w_cube = 1'b1;
        state_next = S_WFIN;
      end
      S_WFIN: begin
        cmd.w_fin  = 1'b1;
        state_next = sts.w_last ? S_TRD : S_WSQ;
      end
      S_TRD: begin
        state_next = S_TMUL;
      end
      S_TMUL: begin
        cmd.t_mul  = 1'b1;
        state_next = S_TACC;
      end
      S_TACC: begin
        cmd.t_acc  = 1'b1;
        state_next = sts.k_last ? S_RMUL : S_TRD;
      end
      S_RMUL: begin
        cmd.r_mul  = 1'b1;
        state_next = S_RACC;
      end
      S_RACC: begin
        cmd.r_acc  = 1'b1;
        state_next = sts.j_last ? S_FIN : S_TRD;
      end
      S_FIN: begin
        cmd.fin    = 1'b1;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (!m_tvalid || m_tready) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
    end
  end

  `IRF_ASSERT_NOW(a_save_after_last, state == S_DIVSAVE, $past(sts.div_last))
  `IRF_ASSERT_NEXT(a_req_to_check, s_tvalid && s_tready && kind, state == S_CHECK)
  `IRF_ASSERT_NEXT(a_done_presents, state == S_DONE && (!m_tvalid || m_tready),
                   m_tvalid && state == S_IDLE)

endmodule

>>> tb/image_resample_forward_tb.sv
// ----------------------------------------------------------------------------
// Image resampler testbench
// Loads small frame-store regions, requests output pixels under every
// interpolation mode, both mappings and several plane sizes (extremes and
// out-of-range register values too). A scoreboard predicts each pixel and
// checks every result transfer with random stalls on both streams.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module image_resample_forward_tb;
  import irf_pkg::*;

  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_REQ  = 1'b1;

  typedef struct {
    logic signed [15:0] pixel;
    logic [7:0]         row;
    logic [7:0]         col;
    logic               status;
  } pixel_t;

  class resample_scoreboard;
    logic signed [15:0] frame[IN_DIM*IN_DIM];
    logic [1:0] mode;
    logic       aligned;
    logic [6:0] in_h, in_w;
    logic [8:0] out_h, out_w;
    pixel_t     pending[$];
    int         errors;
    int         requests;
    int         loads;

    function new();
      mode = MODE_BILINEAR; aligned = 0;
      in_h = 64; in_w = 64; out_h = 64; out_w = 64;
      errors = 0; requests = 0; loads = 0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [8:0] val);
      case (idx)
        REG_MODE:    mode = val[1:0];
        REG_ALIGNED: aligned = val[0];
        REG_IN_H:    in_h = val[6:0];
        REG_IN_W:    in_w = val[6:0];
        REG_OUT_H:   out_h = val;
        REG_OUT_W:   out_w = val;
        default: ;
      endcase
    endfunction

    function int eff(int v, int hi);
      if (v < 1) return 1;
      if (v > hi) return hi;
      return v;
    endfunction

    function longint floor_div(longint n, longint d);
      longint q;
      q = n / d;
      if ((n % d) != 0 && n < 0) q = q - 1;
      return q;
    endfunction

    function longint clip(longint v, int dim);
      if (v < 0) return 0;
      if (v > dim - 1) return dim - 1;
      return v;
    endfunction

    function void src_coord(int o, int isz, int osz, output longint ip,
                            output longint frac, output bit exact);
      longint num, den, q;
      if (aligned && osz <= 1) begin
        ip = 0; frac = 0; exact = 1;
        return;
      end
      if (aligned) begin
        num = longint'(o) * (isz - 1) * 65536;
        den = osz - 1;
      end else begin
        num = ((2 * longint'(o) + 1) * isz - osz) * 65536;
        den = 2 * osz;
      end
      q = floor_div(num, den);
      exact = (num - q * den) == 0;
      ip = floor_div(q, 65536);
      frac = q - ip * 65536;
    endfunction

    function longint round_nearest(longint ip, longint frac, bit exact, int dim);
      if (frac > 32768 || (frac == 32768 && (!exact || ip[0]))) ip = ip + 1;
      return clip(ip, dim);
    endfunction

    function longint keys_weight(longint t, longint a4);
      longint s, num;
      s = 16384;
      if (t < s)
        num = (a4 + 8) * t * t * t - (a4 + 12) * t * t * s + 4 * s * s * s;
      else if (t < 2 * s)
        num = a4 * (t * t * t - 5 * t * t * s + 8 * t * s * s - 4 * s * s * s);
      else
        return 0;
      return floor_div(num + (longint'(1) <<< 29), longint'(1) <<< 30);
    endfunction

    function longint tap(longint r, longint c);
      return longint'(frame[r * IN_DIM + c]);
    endfunction

    function logic signed [15:0] saturate(longint acc);
      longint v;
      v = floor_div(acc + (longint'(1) <<< 27), longint'(1) <<< 28);
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
      return v[15:0];
    endfunction

    function void note_transfer(logic kind, logic [7:0] row, logic [7:0] col,
                                logic signed [15:0] smp);
      int ih, iw, oh, ow, j, k;
      longint yi, yf, xi, xf, qy, qx, s, a4, top, bot, acc, rsum, r;
      bit ye, xe;
      longint wy[4], wx[4];
      pixel_t e;
      ih = eff(in_h, IN_DIM); iw = eff(in_w, IN_DIM);
      oh = eff(out_h, OUT_DIM); ow = eff(out_w, OUT_DIM);
      s = 16384;
      if (kind == KIND_LOAD) begin
        loads++;
        if (row < IN_DIM && col < IN_DIM) frame[row * IN_DIM + col] = smp;
        return;
      end
      requests++;
      e.row = row; e.col = col; e.status = 0; e.pixel = 0;
      if (row >= oh || col >= ow) begin
        e.status = 1;
      end else begin
        src_coord(row, ih, oh, yi, yf, ye);
        src_coord(col, iw, ow, xi, xf, xe);
        qy = (yf + 2) >>> 2;
        qx = (xf + 2) >>> 2;
        if (mode == MODE_NEAREST) begin
          e.pixel = frame[round_nearest(yi, yf, ye, ih) * IN_DIM
                          + round_nearest(xi, xf, xe, iw)];
        end else if (mode == MODE_BILINEAR) begin
          top = tap(clip(yi, ih), clip(xi, iw)) * (s - qx)
              + tap(clip(yi, ih), clip(xi + 1, iw)) * qx;
          bot = tap(clip(yi + 1, ih), clip(xi, iw)) * (s - qx)
              + tap(clip(yi + 1, ih), clip(xi + 1, iw)) * qx;
          e.pixel = saturate(top * (s - qy) + bot * qy);
        end else begin
          a4 = (mode == MODE_CUBIC75) ? -3 : -2;
          wy[0] = keys_weight(s + qy, a4);     wx[0] = keys_weight(s + qx, a4);
          wy[1] = keys_weight(qy, a4);         wx[1] = keys_weight(qx, a4);
          wy[2] = keys_weight(s - qy, a4);     wx[2] = keys_weight(s - qx, a4);
          wy[3] = keys_weight(2 * s - qy, a4); wx[3] = keys_weight(2 * s - qx, a4);
          acc = 0;
          for (j = 0; j < 4; j++) begin
            r = clip(yi + j - 1, ih);
            rsum = 0;
            for (k = 0; k < 4; k++) rsum += wx[k] * tap(r, clip(xi + k - 1, iw));
            acc += wy[j] * rsum;
          end
          e.pixel = saturate(acc);
        end
      end
      pending.push_back(e);
    endfunction

    function void check_pixel(logic [31:0] data, logic user);
      pixel_t e;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result transfer: tdata=%h tuser=%b", data, user);
        return;
      end
      e = pending.pop_front();
      if (data[15:0] !== e.pixel || data[23:16] !== e.row || data[31:24] !== e.col
          || user !== e.status) begin
        errors++;
        if (errors <= 10)
          $display({"mismatch at (%0d,%0d): expected pixel=%0d status=%b, ",
                    "got row=%0d col=%0d pixel=%0d status=%b"},
                   e.row, e.col, e.pixel, e.status, data[23:16], data[31:24],
                   $signed(data[15:0]), user);
      end
    endfunction
  endclass

  logic        clk, rst;
  logic        s_tvalid, s_tready, s_tuser;
  logic [31:0] s_tdata;
  logic        m_tvalid, m_tready, m_tuser;
  logic [31:0] m_tdata;
  logic        cfg_valid, cfg_ready;
  logic [2:0]  cfg_index;
  logic [8:0]  cfg_data;

  resample_scoreboard sb;
  bit quiet;
  int phases;

  image_resample_forward DUT (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("Verification failed");
    $finish;
  end

  task automatic send(logic kind, logic [7:0] row, logic [7:0] col, logic [15:0] smp);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      s_tvalid <= 0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1;
    s_tuser <= kind;
    s_tdata <= {smp, col, row};
    do @(posedge clk); while (!s_tready);
    sb.note_transfer(kind, row, col, smp);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [8:0] val);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    sb.set_reg(idx, val);
    cfg_valid <= 0;
    @(posedge clk);
  endtask

  task automatic drain();
    s_tvalid <= 0;
    while (sb.pending.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  function automatic logic [15:0] rand_sample();
    case ($urandom_range(0, 5))
      0: return 16'h7fff;
      1: return 16'h8000;
      default: return 16'($urandom());
    endcase
  endfunction

  task automatic run_phase(logic [1:0] md, logic al, logic [6:0] ih, logic [6:0] iw,
                           logic [8:0] oh, logic [8:0] ow, int nrand);
    int eh, ew, fh, fw, r, c, n;
    drain();
    write_reg(REG_MODE, 9'(md));
    write_reg(REG_ALIGNED, 9'(al));
    write_reg(REG_IN_H, 9'(ih));
    write_reg(REG_IN_W, 9'(iw));
    write_reg(REG_OUT_H, oh);
    write_reg(REG_OUT_W, ow);
    phases++;
    quiet = ($urandom_range(0, 3) == 0);
    eh = sb.eff(int'(ih), IN_DIM); ew = sb.eff(int'(iw), IN_DIM);
    fh = sb.eff(int'(oh), OUT_DIM); fw = sb.eff(int'(ow), OUT_DIM);
    for (r = 0; r < eh; r++)
      for (c = 0; c < ew; c++) send(KIND_LOAD, 8'(r), 8'(c), rand_sample());
    for (n = 0; n < nrand; n++) begin
      if (n == nrand / 2) drain();
      case ($urandom_range(0, 19))
        0: send(KIND_LOAD, 8'($urandom_range(64, 255)), 8'($urandom()), 16'($urandom()));
        1, 2, 3, 4:
          send(KIND_LOAD, 8'($urandom_range(0, eh - 1)), 8'($urandom_range(0, ew - 1)),
               rand_sample());
        5: send(KIND_REQ, 8'($urandom()), 8'($urandom()), 16'($urandom()));
        default:
          send(KIND_REQ, 8'($urandom_range(0, fh - 1)), 8'($urandom_range(0, fw - 1)),
               16'($urandom()));
      endcase
    end
  endtask

  initial begin
    int receive_gap;
    m_tready = 0;
    @(negedge rst);
    forever begin
      receive_gap = quiet ? 0 : $urandom_range(0, 16);
      if (receive_gap > 0) begin
        m_tready <= 0;
        repeat (receive_gap) @(posedge clk);
      end
      m_tready <= 1;
      do @(posedge clk); while (!m_tvalid);
      sb.check_pixel(m_tdata, m_tuser);
    end
  end

  initial begin
    int p, ih, iw;
    sb = new();
    phases = 0;
    quiet = 0;
    rst = 1;
    s_tvalid = 0; s_tuser = 0; s_tdata = 0;
    cfg_valid = 0; cfg_index = 0; cfg_data = 0;
    repeat (7) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: exact ties under nearest, store extremes, ignored loads, out-of-range requests, other modes
    run_phase(MODE_NEAREST, 0, 8, 8, 4, 4, 0);
    send(KIND_LOAD, 0, 0, 16'h7fff);
    send(KIND_LOAD, 7, 7, 16'h8000);
    send(KIND_LOAD, 255, 255, 16'hffff);
    send(KIND_LOAD, 64, 3, 16'h1234);
    send(KIND_LOAD, 3, 64, 16'h4321);
    send(KIND_REQ, 0, 0, 0);
    send(KIND_REQ, 3, 3, 16'hffff);
    send(KIND_REQ, 1, 2, 0);
    send(KIND_REQ, 255, 0, 0);
    send(KIND_REQ, 0, 255, 0);
    send(KIND_REQ, 4, 3, 0);
    drain();
    write_reg(REG_MODE, 9'(MODE_BILINEAR));
    send(KIND_REQ, 3, 3, 0);
    drain();
    write_reg(REG_MODE, 9'(MODE_CUBIC50));
    send(KIND_REQ, 3, 3, 0);
    drain();
    write_reg(REG_MODE, 9'(MODE_CUBIC75));
    send(KIND_REQ, 0, 0, 0);
    drain();

    run_phase(MODE_BILINEAR, 1, 1, 64, 1, 256, 90);
    run_phase(MODE_CUBIC50, 0, 64, 2, 256, 3, 90);
    run_phase(MODE_CUBIC75, 1, 5, 7, 3, 2, 80);
    run_phase(MODE_CUBIC50, 1, 0, 100, 0, 511, 80);
    run_phase(MODE_NEAREST, 1, 7, 3, 1, 9, 60);
    for (p = 0; p < 10; p++) begin
      ih = $urandom_range(1, 8);
      iw = $urandom_range(1, 8);
      run_phase(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)), 7'(ih), 7'(iw),
                9'($urandom_range(1, 40)), 9'($urandom_range(1, 40)), 70);
    end
    drain();
    repeat (200) @(posedge clk);

    $display("Covered %0d configurations: %0d loads and %0d pixel requests.",
             phases, sb.loads, sb.requests);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("%0d mismatches, %0d results missing", sb.errors, sb.pending.size());
      $display("Verification failed");
    end
    $finish;
  end

endmodule
